### src/imra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imra_pkg: shared types for the interval map range assign block
// Holds the command codes, the transaction structs and the sequencer states.
// ----------------------------------------------------------------------------
package imra_pkg;

	localparam int KeyW = 32;
	localparam int ValW = 8;

	typedef enum logic {
		CMD_ASSIGN = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef struct packed {
		logic            cmd;
		logic [KeyW-1:0] range_begin;
		logic [KeyW-1:0] range_end;
		logic [ValW-1:0] assign_value;
		logic [KeyW-1:0] query_key;
	} req_t;

	typedef struct packed {
		logic [ValW-1:0] read_value;
		logic            status;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_LOOK,
		ST_SCAN,
		ST_MID,
		ST_TAIL,
		ST_CHECK,
		ST_COPY,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

### src/imra_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imra_ram: generic single-port-write, single-read synchronous ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module imra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### src/interval_map_range_assign_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_map_range_assign_top: sorted breakpoint table with range assign
// Keeps (key, value) breakpoints in ram; assign rebuilds the table through a
// scratch ram, copied back unless it overflows; lookup scans the live table.
// ----------------------------------------------------------------------------
//  channel   signals                      direction
//  request   start, busy, req             in (accepted: start & !busy)
//  result    done, rsp                    out (one cycle strobe)
//  config    cfg_we, cfg_wdata            in (default value, resets table)
//
// A lookup reads each stored entry from the key/value ram in turn between
// the accept cycle and the result strobe. An assign makes a scan of the old
// table for the end value, a rebuild pass into scratch ram, and a copy back;
// an empty range goes straight to the result strobe. Reset or a config write
// leaves one entry (0, default), written in the cycle after, during which
// busy stays high. The result strobe cannot be held off.
// ----------------------------------------------------------------------------
module interval_map_range_assign_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire imra_pkg::req_t req,
	output logic               done,
	output imra_pkg::rsp_t     rsp,
	input  wire logic          cfg_we,
	input  wire logic [imra_pkg::ValW-1:0] cfg_wdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = imra_pkg::KeyW;
	localparam int VW = imra_pkg::ValW;
	localparam int EW = KW + VW;
	localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

	imra_pkg::state_t state_q, state_d;
	imra_pkg::req_t   req_q;
	logic [VW-1:0] dflt_q;
	logic [CW-1:0] cnt_q;      // live entry count
	logic [CW-1:0] idx_q;      // read index into live table
	logic [CW-1:0] ncnt_q;     // entries pushed into scratch
	logic          ovf_q;
	logic          rd_vld_q;   // read data of the previous cycle is valid
	logic [VW-1:0] acc_q;      // lookup value / end_old
	logic [VW-1:0] last_q;     // last pushed value
	logic          init_q;     // init write pending
	logic          e_pend_q;   // end breakpoint push pending

	// live table ram
	logic          t_we;
	logic [AW-1:0] t_waddr, t_raddr;
	logic [EW-1:0] t_wdata, t_rdata;
	// scratch ram
	logic          s_we;
	logic [AW-1:0] s_waddr, s_raddr;
	logic [EW-1:0] s_wdata, s_rdata;

	imra_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_tab (
		.clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);
	imra_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_scr (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	logic [KW-1:0] rk;
	logic [VW-1:0] rv;
	logic          scan_end;
	logic          push;
	logic [KW-1:0] push_k;
	logic [VW-1:0] push_v;
	logic          accept;

	assign rk       = t_rdata[EW-1:VW];
	assign rv       = t_rdata[VW-1:0];
	assign busy     = (state_q != imra_pkg::ST_IDLE) || init_q;
	assign accept   = start && !busy;
	assign scan_end = (idx_q >= cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			imra_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.cmd == imra_pkg::CMD_LOOKUP) begin
						state_d = imra_pkg::ST_LOOK;
					end else if (req.range_begin >= req.range_end) begin
						state_d = imra_pkg::ST_DONE;
					end else begin
						state_d = imra_pkg::ST_LOOK;
					end
				end
			end
			imra_pkg::ST_INIT: state_d = imra_pkg::ST_IDLE;
			imra_pkg::ST_LOOK: begin
				if (scan_end && rd_vld_q) begin
					state_d = (req_q.cmd == imra_pkg::CMD_LOOKUP) ?
						imra_pkg::ST_DONE : imra_pkg::ST_SCAN;
				end
			end
			imra_pkg::ST_SCAN: begin
				if (rd_vld_q && rk >= req_q.range_begin) begin
					state_d = imra_pkg::ST_MID;
				end else if (scan_end && rd_vld_q) begin
					state_d = imra_pkg::ST_MID;
				end
			end
			imra_pkg::ST_MID:  state_d = imra_pkg::ST_TAIL;
			imra_pkg::ST_TAIL: begin
				if (scan_end && (rd_vld_q || idx_q == cnt_q)) begin
					state_d = imra_pkg::ST_CHECK;
				end
			end
			imra_pkg::ST_CHECK: state_d = ovf_q ? imra_pkg::ST_DONE : imra_pkg::ST_COPY;
			imra_pkg::ST_COPY: begin
				if (idx_q >= ncnt_q && !rd_vld_q) begin
					state_d = imra_pkg::ST_DONE;
				end
			end
			imra_pkg::ST_DONE: state_d = imra_pkg::ST_IDLE;
			default: state_d = imra_pkg::ST_IDLE;
		endcase
	end

	// scratch push and ram control
	always_comb begin
		push   = 1'b0;
		push_k = rk;
		push_v = rv;
		t_we    = 1'b0;
		t_waddr = '0;
		t_wdata = {{KW{1'b0}}, dflt_q};
		t_raddr = idx_q[AW-1:0];
		s_raddr = idx_q[AW-1:0];
		case (state_q)
			imra_pkg::ST_IDLE: begin
				// entry 0 is ready when a transaction enters the scan
				t_raddr = '0;
			end
			imra_pkg::ST_SCAN: begin
				if (rd_vld_q && rk < req_q.range_begin) begin
					push = 1'b1;
				end
			end
			imra_pkg::ST_MID: begin
				if (ncnt_q == '0 || last_q != req_q.assign_value) begin
					push   = 1'b1;
					push_k = req_q.range_begin;
					push_v = req_q.assign_value;
				end
			end
			imra_pkg::ST_TAIL: begin
				if (e_pend_q) begin
					push   = 1'b1;
					push_k = req_q.range_end;
					push_v = acc_q;
				end else if (rd_vld_q && rk > req_q.range_end) begin
					push = 1'b1;
				end
			end
			imra_pkg::ST_COPY: begin
				if (rd_vld_q) begin
					t_we    = 1'b1;
					t_waddr = AW'(idx_q - CW'(1));
					t_wdata = s_rdata;
				end
			end
			default: begin
			end
		endcase
		if (init_q) begin
			t_we    = 1'b1;
			t_waddr = '0;
			t_wdata = {{KW{1'b0}}, dflt_q};
		end
		s_we    = push && (ncnt_q < DepthC);
		s_waddr = ncnt_q[AW-1:0];
		s_wdata = {push_k, push_v};
	end

	// outputs
	always_comb begin
		done = (state_q == imra_pkg::ST_DONE);
		rsp.read_value = (req_q.cmd == imra_pkg::CMD_LOOKUP) ? acc_q : '0;
		rsp.status = (req_q.cmd == imra_pkg::CMD_ASSIGN) && ovf_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= imra_pkg::ST_INIT;
			dflt_q   <= VW'(65);
			cnt_q    <= CW'(1);
			idx_q    <= '0;
			ncnt_q   <= '0;
			ovf_q    <= 1'b0;
			rd_vld_q <= 1'b0;
			init_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			init_q  <= 1'b0;
			if (cfg_we) begin
				dflt_q <= cfg_wdata;
				cnt_q  <= CW'(1);
				init_q <= 1'b1;
			end
			case (state_q)
				imra_pkg::ST_IDLE: begin
					idx_q    <= '0;
					ncnt_q   <= '0;
					ovf_q    <= 1'b0;
					rd_vld_q <= 1'b0;
					if (accept && !(req.cmd == imra_pkg::CMD_ASSIGN &&
							req.range_begin >= req.range_end)) begin
						idx_q    <= CW'(1);
						rd_vld_q <= 1'b1;
					end
				end
				imra_pkg::ST_LOOK: begin
					if (scan_end && rd_vld_q) begin
						idx_q    <= CW'(1);
						rd_vld_q <= 1'b0;
					end else begin
						rd_vld_q <= !scan_end;
						if (!scan_end) begin
							idx_q <= idx_q + CW'(1);
						end
					end
					// rescan from entry 0; its read data comes the cycle after scan starts
					if (state_d == imra_pkg::ST_SCAN) begin
						idx_q    <= '0;
						rd_vld_q <= 1'b0;
					end
				end
				imra_pkg::ST_SCAN: begin
					rd_vld_q <= !scan_end;
					if (!scan_end) begin
						idx_q <= idx_q + CW'(1);
					end
					if (state_d == imra_pkg::ST_MID) begin
						idx_q    <= idx_q - CW'(1);
						rd_vld_q <= 1'b0;
						if (scan_end && !(rk >= req_q.range_begin)) begin
							idx_q <= cnt_q;
						end
					end
				end
				imra_pkg::ST_MID: begin
					rd_vld_q <= 1'b0;
				end
				imra_pkg::ST_TAIL: begin
					rd_vld_q <= !scan_end;
					if (!scan_end) begin
						idx_q <= idx_q + CW'(1);
					end
					if (state_d == imra_pkg::ST_CHECK) begin
						idx_q <= '0;
					end
				end
				imra_pkg::ST_CHECK: begin
					idx_q    <= CW'(1);
					rd_vld_q <= 1'b1;
				end
				imra_pkg::ST_COPY: begin
					rd_vld_q <= (idx_q < ncnt_q);
					if (idx_q < ncnt_q) begin
						idx_q <= idx_q + CW'(1);
					end
					if (state_d == imra_pkg::ST_DONE) begin
						cnt_q <= ncnt_q;
					end
				end
				default: begin
				end
			endcase
			// scratch fill count and overflow
			if (push) begin
				if (ncnt_q >= DepthC) begin
					ovf_q <= 1'b1;
				end else begin
					ncnt_q <= ncnt_q + CW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			acc_q <= rv;
		end
		if (state_q == imra_pkg::ST_LOOK && rd_vld_q) begin
			if (req_q.cmd == imra_pkg::CMD_LOOKUP) begin
				if (rk <= req_q.query_key) acc_q <= rv;
			end else begin
				if (rk <= req_q.range_end) acc_q <= rv;
			end
		end
		if (push) begin
			last_q <= push_v;
		end
	end

	// end breakpoint is pushed in the first tail cycle, before any tail entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_pend_q <= 1'b0;
		end else begin
			e_pend_q <= (state_q == imra_pkg::ST_MID) && (acc_q != req_q.assign_value);
		end
	end

endmodule
`default_nettype wire
